// File: rtl/lss_pkg.sv
// Shared types, codes and command/status bundles for the LIFO stack with search.
`default_nettype none

package lss_pkg;

  localparam int OP_W   = 2;
  localparam int WORD_W = 32;
  localparam int STAT_W = 3;
  localparam int POS_W  = 5;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH   = 2'd0,
    OP_POP    = 2'd1,
    OP_PEEK   = 2'd2,
    OP_SEARCH = 2'd3
  } op_e_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_PUSHED   = 3'd0,
    STAT_FULL     = 3'd1,
    STAT_POPPED   = 3'd2,
    STAT_EMPTY    = 3'd3,
    STAT_TOP      = 3'd4,
    STAT_FOUND    = 3'd5,
    STAT_NOTFOUND = 3'd6
  } status_e_t;

  typedef enum logic [1:0] {
    WSEL_ZERO = 2'd0,
    WSEL_READ = 2'd1,
    WSEL_KEY  = 2'd2
  } wsel_e_t;

  typedef enum logic [1:0] {
    S_IDLE  = 2'd0,
    S_OP    = 2'd1,
    S_SCAN  = 2'd2,
    S_FLUSH = 2'd3
  } state_e_t;

  typedef struct packed {
    logic      load;
    logic      pos_init;
    logic      pos_adv;
    logic      push_wr;
    logic      pop;
    logic      emit;
    status_e_t emit_status;
    wsel_e_t   word_sel;
    logic      pos_pend;
    logic      emit_last;
    logic      pend_set;
    logic      pend_clr;
  } cmd_t;

  typedef struct packed {
    op_e_t op;
    logic  empty;
    logic  full;
    logic  match;
    logic  scan_end;
    logic  pend_valid;
    logic  slot_free;
  } sts_t;

endpackage

`default_nettype wire

// File: rtl/lss_in_if.sv
// Input channel: one operation and its operand per beat.
`default_nettype none

interface lss_in_if;
  logic                             valid;
  logic                             ready;
  logic [lss_pkg::OP_W-1:0]         op;
  logic signed [lss_pkg::WORD_W-1:0] value;

  modport source (output valid, op, value, input ready);
  modport sink   (input valid, op, value, output ready);
endinterface

`default_nettype wire

// File: rtl/lss_out_if.sv
// Result channel: one result item per beat.
`default_nettype none

interface lss_out_if;
  logic                              valid;
  logic                              ready;
  logic [lss_pkg::STAT_W-1:0]        status;
  logic signed [lss_pkg::WORD_W-1:0] word;
  logic [lss_pkg::POS_W-1:0]         position;
  logic                              last;

  modport source (output valid, status, word, position, last, input ready);
  modport sink   (input valid, status, word, position, last, output ready);
endinterface

`default_nettype wire

// File: rtl/lifo_stack_with_search.sv
// Top level of the bounded LIFO stack with linear search.
//
//  channel | direction | beat carries
//  --------+-----------+---------------------------------------------
//  in_ch   | in        | op (push, pop, peek, search), value
//  out_ch  | out       | status, word, position, last
//
// An operation beat is taken only when the controller is idle; each beat then
// runs to its final result. Push, pop and peek are taken in the idle state and
// write their result into the result register from the operation state. Search
// visits one stored entry per cycle through the single memory read port while
// the result channel does not stall it; on an empty stack it reports not found
// from the operation state without a scan. The result register lets the block
// go on while a result waits; a stalled result channel holds the scan. Reset is
// synchronous and empties the stack.
`default_nettype none

module lifo_stack_with_search #(
  parameter int DEPTH = 16
) (
  input  wire logic clk,
  input  wire logic rst_n,
  lss_in_if.sink    in_ch,
  lss_out_if.source out_ch
);
  import lss_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic in_ready;

  assign in_ch.ready = in_ready;

  lss_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  lss_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_op    (in_ch.op),
    .in_value (in_ch.value),
    .cmd      (cmd),
    .sts      (sts),
    .out_ch   (out_ch)
  );

  // A new result must never overwrite one that has not yet left.
  a_emit_slot : assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> sts.slot_free)
    else $error("result written over a waiting result");

  // A push that stores a word needs room in the stack.
  a_push_room : assert property (@(posedge clk) disable iff (!rst_n)
    cmd.push_wr |-> !sts.full)
    else $error("push written into a full stack");

  // A held match never survives into the next operation.
  a_pend_idle : assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !sts.pend_valid)
    else $error("held match left over when idle");

  // The controller ends every operation with one result marked last.
  a_last_idle : assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit && cmd.emit_last) |=> in_ready)
    else $error("final result not followed by idle");

endmodule

`default_nettype wire

// File: rtl/lss_ctrl.sv
// Controller state machine sequencing stack operations and the search scan.
`default_nettype none

module lss_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire lss_pkg::sts_t sts,
  output lss_pkg::cmd_t      cmd
);
  import lss_pkg::*;

  state_e_t state_r;
  state_e_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready     = 1'b1;
        cmd.pos_init = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_OP;
        end
      end
      S_OP: begin
        cmd.emit_last = 1'b1;
        unique case (sts.op)
          OP_PUSH: begin
            if (sts.slot_free) begin
              cmd.emit = 1'b1;
              if (sts.full) begin
                cmd.emit_status = STAT_FULL;
              end else begin
                cmd.emit_status = STAT_PUSHED;
                cmd.push_wr     = 1'b1;
              end
              state_nxt = S_IDLE;
            end
          end
          OP_POP: begin
            if (sts.slot_free) begin
              cmd.emit = 1'b1;
              if (sts.empty) begin
                cmd.emit_status = STAT_EMPTY;
              end else begin
                cmd.emit_status = STAT_POPPED;
                cmd.word_sel    = WSEL_READ;
                cmd.pop         = 1'b1;
              end
              state_nxt = S_IDLE;
            end
          end
          OP_PEEK: begin
            if (sts.slot_free) begin
              cmd.emit = 1'b1;
              if (sts.empty) begin
                cmd.emit_status = STAT_EMPTY;
              end else begin
                cmd.emit_status = STAT_TOP;
                cmd.word_sel    = WSEL_READ;
              end
              state_nxt = S_IDLE;
            end
          end
          OP_SEARCH: begin
            cmd.pend_clr = 1'b1;
            if (sts.empty) begin
              if (sts.slot_free) begin
                cmd.emit        = 1'b1;
                cmd.emit_status = STAT_NOTFOUND;
                state_nxt       = S_IDLE;
              end
            end else begin
              state_nxt = S_SCAN;
            end
          end
        endcase
      end
      S_SCAN: begin
        // A match is held back until the next one, or the end of the scan,
        // shows whether it is the deepest.
        if (sts.match && sts.pend_valid) begin
          if (sts.slot_free) begin
            cmd.emit        = 1'b1;
            cmd.emit_status = STAT_FOUND;
            cmd.word_sel    = WSEL_KEY;
            cmd.pos_pend    = 1'b1;
            cmd.pend_set    = 1'b1;
            if (sts.scan_end) begin
              state_nxt = S_FLUSH;
            end else begin
              cmd.pos_adv = 1'b1;
            end
          end
        end else begin
          cmd.pend_set = sts.match;
          if (sts.scan_end) begin
            state_nxt = S_FLUSH;
          end else begin
            cmd.pos_adv = 1'b1;
          end
        end
      end
      S_FLUSH: begin
        if (sts.slot_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_last = 1'b1;
          cmd.pend_clr  = 1'b1;
          if (sts.pend_valid) begin
            cmd.emit_status = STAT_FOUND;
            cmd.word_sel    = WSEL_KEY;
            cmd.pos_pend    = 1'b1;
          end else begin
            cmd.emit_status = STAT_NOTFOUND;
          end
          state_nxt = S_IDLE;
        end
      end
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/lss_dpath.sv
// Datapath: entry memory, fill count, scan position, held match and result register.
`default_nettype none

module lss_dpath #(
  parameter int DEPTH = 16
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic [lss_pkg::OP_W-1:0]           in_op,
  input  wire logic signed [lss_pkg::WORD_W-1:0]  in_value,
  input  wire lss_pkg::cmd_t                      cmd,
  output lss_pkg::sts_t                           sts,
  lss_out_if.source                               out_ch
);
  import lss_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int PW = $clog2(DEPTH + 2);

  logic signed [WORD_W-1:0] mem [DEPTH];
  logic signed [WORD_W-1:0] rd_data_r;
  logic [AW-1:0]            rd_addr;

  logic [CW-1:0]            cnt_r;
  logic [CW-1:0]            cnt_nxt;
  logic [PW-1:0]            pos_r;
  logic [PW-1:0]            pos_nxt;
  logic [PW-1:0]            pend_pos_r;
  logic                     pend_valid_r;
  logic                     pend_valid_nxt;
  op_e_t                    op_r;
  logic signed [WORD_W-1:0] key_r;

  logic                     out_valid_r;
  logic                     out_valid_nxt;
  logic [STAT_W-1:0]        out_status_r;
  logic signed [WORD_W-1:0] out_word_r;
  logic signed [WORD_W-1:0] word_mux;
  logic [POS_W-1:0]         out_pos_r;
  logic                     out_last_r;

  always_comb begin
    priority if (cmd.pos_init) begin
      pos_nxt = PW'(1);
    end else if (cmd.pos_adv) begin
      pos_nxt = pos_r + PW'(1);
    end else begin
      pos_nxt = pos_r;
    end
  end

  // The read data always shows the entry at the scan position counted from the top.
  always_comb begin
    logic [PW-1:0] diff;
    diff    = PW'(cnt_r) - pos_nxt;
    rd_addr = diff[AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.push_wr) begin
      mem[cnt_r[AW-1:0]] <= key_r;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (cmd.push_wr) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (cmd.pop) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_comb begin
    pend_valid_nxt = pend_valid_r;
    if (cmd.pend_clr) begin
      pend_valid_nxt = 1'b0;
    end
    if (cmd.pend_set) begin
      pend_valid_nxt = 1'b1;
    end
  end

  assign out_valid_nxt = cmd.emit ? 1'b1 : (out_ch.ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r        <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      cnt_r        <= cnt_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_comb begin
    unique case (cmd.word_sel)
      WSEL_READ: word_mux = rd_data_r;
      WSEL_KEY:  word_mux = key_r;
      default:   word_mux = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    pos_r <= pos_nxt;
    if (cmd.load) begin
      op_r  <= op_e_t'(in_op);
      key_r <= in_value;
    end
    if (cmd.pend_set) begin
      pend_pos_r <= pos_r;
    end
    if (cmd.emit) begin
      out_status_r <= cmd.emit_status;
      out_word_r   <= word_mux;
      out_pos_r    <= cmd.pos_pend ? POS_W'(pend_pos_r) : '0;
      out_last_r   <= cmd.emit_last;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.status   = out_status_r;
  assign out_ch.word     = out_word_r;
  assign out_ch.position = out_pos_r;
  assign out_ch.last     = out_last_r;

  assign sts.op         = op_r;
  assign sts.empty      = (cnt_r == '0);
  assign sts.full       = (cnt_r == CW'(DEPTH));
  assign sts.match      = (rd_data_r == key_r);
  assign sts.scan_end   = (pos_r == PW'(cnt_r));
  assign sts.pend_valid = pend_valid_r;
  assign sts.slot_free  = !out_valid_r || out_ch.ready;

endmodule

`default_nettype wire

// File: bench/lifo_stack_with_search_test.sv
// Self-checking bench for the LIFO stack with search: random operations against a mirror stack.
`timescale 1ns / 100ps

module lifo_stack_with_search_test;
  import lss_pkg::*;

  localparam int DEPTH       = 16;
  localparam int RANDOM_OPS  = 400;
  localparam int LONG_HOLD   = 400;
  localparam int CYCLE_LIMIT = 2000000;

  typedef struct packed {
    status_e_t          status;
    logic [WORD_W-1:0]  word;
    logic [POS_W-1:0]   position;
    logic               last;
  } stack_result_t;

  // Mirror of the stack contents and the results each operation should produce.
  class lifo_mirror;
    logic [WORD_W-1:0] slots[DEPTH];
    int                fill;
    stack_result_t     pending[$];
    int                errors;

    function new();
      fill   = 0;
      errors = 0;
    endfunction

    function stack_result_t make(status_e_t st, logic [WORD_W-1:0] w,
                                 logic [POS_W-1:0] pos, logic lst);
      stack_result_t r;
      r.status   = st;
      r.word     = w;
      r.position = pos;
      r.last     = lst;
      return r;
    endfunction

    function void note_op(op_e_t op, logic [WORD_W-1:0] value);
      int hits;
      case (op)
        OP_PUSH: begin
          if (fill >= DEPTH) begin
            pending.push_back(make(STAT_FULL, '0, '0, 1'b1));
          end else begin
            slots[fill] = value;
            fill++;
            pending.push_back(make(STAT_PUSHED, '0, '0, 1'b1));
          end
        end
        OP_POP: begin
          if (fill == 0) begin
            pending.push_back(make(STAT_EMPTY, '0, '0, 1'b1));
          end else begin
            fill--;
            pending.push_back(make(STAT_POPPED, slots[fill], '0, 1'b1));
          end
        end
        OP_PEEK: begin
          if (fill == 0) begin
            pending.push_back(make(STAT_EMPTY, '0, '0, 1'b1));
          end else begin
            pending.push_back(make(STAT_TOP, slots[fill-1], '0, 1'b1));
          end
        end
        default: begin
          hits = 0;
          // Walk from the top down; only the deepest match closes the item.
          for (int i = 1; i <= fill; i++) begin
            if (slots[fill-i] == value) begin
              pending.push_back(make(STAT_FOUND, value, POS_W'(i), 1'b0));
              hits++;
            end
          end
          if (hits == 0) begin
            pending.push_back(make(STAT_NOTFOUND, '0, '0, 1'b1));
          end else begin
            pending[pending.size()-1].last = 1'b1;
          end
        end
      endcase
    endfunction

    task report(string msg);
      if (errors < 50) begin
        $display("MISMATCH at %0t: %s", $time, msg);
      end
      errors++;
    endtask

    task check_result(logic [STAT_W-1:0] st, logic [WORD_W-1:0] w,
                      logic [POS_W-1:0] pos, logic lst);
      stack_result_t want;
      if (pending.size() == 0) begin
        report($sformatf("unexpected result status %0d word %h", st, w));
      end else begin
        want = pending.pop_front();
        if (st !== want.status) begin
          report($sformatf("status %0d, expected %s", st, want.status.name()));
        end
        if (w !== want.word) begin
          report($sformatf("word %h, expected %h", w, want.word));
        end
        if (pos !== want.position) begin
          report($sformatf("position %0d, expected %0d", pos, want.position));
        end
        if (lst !== want.last) begin
          report($sformatf("last %b, expected %b", lst, want.last));
        end
      end
    endtask
  endclass

  logic clk;
  logic rst_n;
  int   cycles;
  int   ops_accepted;
  int   sender_free_run;
  bit   long_hold_done;
  logic [WORD_W-1:0] word_pool[8];

  lifo_mirror stack_mirror = new();

  lss_in_if  op_bus();
  lss_out_if res_bus();

  lifo_stack_with_search #(.DEPTH(DEPTH)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (op_bus),
    .out_ch (res_bus)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && res_bus.valid && res_bus.ready) begin
      stack_mirror.check_result(res_bus.status, res_bus.word, res_bus.position,
                                res_bus.last);
    end
  end

  // Result side: short random stalls, stretches of steady readiness, and one
  // long hold-off that backs the block up into its input.
  initial begin : result_sink
    int hold;
    int free_run;
    int r;
    hold     = 0;
    free_run = 0;
    res_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst_n) begin
        res_bus.ready <= 1'b0;
      end else if (hold > 0) begin
        res_bus.ready <= 1'b0;
        hold--;
      end else if (!long_hold_done && ops_accepted >= 150) begin
        long_hold_done = 1'b1;
        hold = LONG_HOLD;
        res_bus.ready <= 1'b0;
      end else begin
        res_bus.ready <= 1'b1;
        if (free_run > 0) begin
          free_run--;
        end else begin
          r = $urandom_range(0, 99);
          if (r < 50) hold = 0;
          else if (r < 85) hold = $urandom_range(1, 3);
          else if (r < 95) hold = $urandom_range(5, 40);
          else free_run = $urandom_range(20, 100);
        end
      end
    end
  end

  function automatic int pick_gap();
    int r;
    if (sender_free_run > 0) begin
      sender_free_run--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(5, 40);
    sender_free_run = $urandom_range(15, 60);
    return 0;
  endfunction

  function automatic logic [WORD_W-1:0] pick_word();
    if ($urandom_range(0, 9) < 6) return word_pool[$urandom_range(0, 7)];
    return $urandom;
  endfunction

  // Offer one beat and hold it until it is taken. Valid is only lowered when a
  // gap follows, so back-to-back beats keep it high without a glitch.
  task automatic send_op(op_e_t op, logic [WORD_W-1:0] value);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      op_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    op_bus.valid <= 1'b1;
    op_bus.op    <= op;
    op_bus.value <= value;
    @(posedge clk);
    while (!op_bus.ready) @(posedge clk);
    stack_mirror.note_op(op, value);
    ops_accepted++;
  endtask

  initial begin : stimulus
    int phase;
    int r;
    op_e_t op;
    logic [WORD_W-1:0] same_word;

    cycles          = 0;
    ops_accepted    = 0;
    sender_free_run = 0;
    long_hold_done  = 1'b0;
    rst_n           = 1'b0;
    op_bus.valid    <= 1'b0;
    op_bus.op       <= OP_PUSH;
    op_bus.value    <= '0;
    word_pool[0] = 32'h0000_0000;
    word_pool[1] = 32'hFFFF_FFFF;
    word_pool[2] = 32'h8000_0000;
    word_pool[3] = 32'h7FFF_FFFF;
    for (int i = 4; i < 8; i++) word_pool[i] = $urandom;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty cases, extremes, filling to the brim, a refused push and
    // searches with many hits, the deepest hit and no hit at all.
    send_op(OP_POP, '0);
    send_op(OP_PEEK, '0);
    send_op(OP_SEARCH, 32'h0000_0000);
    send_op(OP_PUSH, 32'h8000_0000);
    send_op(OP_PUSH, 32'h7FFF_FFFF);
    send_op(OP_PUSH, 32'hFFFF_FFFF);
    send_op(OP_PUSH, 32'h0000_0000);
    for (int i = 0; i < DEPTH - 4; i++) send_op(OP_PUSH, 32'h7FFF_FFFF);
    send_op(OP_PUSH, 32'h0000_0001);
    send_op(OP_SEARCH, 32'h7FFF_FFFF);
    send_op(OP_SEARCH, 32'h8000_0000);
    send_op(OP_SEARCH, 32'h1234_5678);
    send_op(OP_PEEK, '0);
    send_op(OP_POP, '0);

    phase     = 0;
    same_word = word_pool[0];
    for (int n = 0; n < RANDOM_OPS; n++) begin
      if (n % 40 == 0) begin
        phase     = $urandom_range(0, 3);
        same_word = pick_word();
      end
      r = $urandom_range(0, 99);
      case (phase)
        0:       op = (r < 65) ? OP_PUSH : (r < 75) ? OP_POP : (r < 80) ? OP_PEEK : OP_SEARCH;
        1:       op = (r < 15) ? OP_PUSH : (r < 70) ? OP_POP : (r < 80) ? OP_PEEK : OP_SEARCH;
        2:       op = (r < 35) ? OP_PUSH : (r < 60) ? OP_POP : (r < 70) ? OP_PEEK : OP_SEARCH;
        default: op = (r < 60) ? OP_PUSH : (r < 70) ? OP_POP : (r < 75) ? OP_PEEK : OP_SEARCH;
      endcase
      // The last phase keeps pushing and seeking one word, so searches can
      // hit every entry of a full stack.
      if (phase == 3 && $urandom_range(0, 9) < 8) send_op(op, same_word);
      else send_op(op, pick_word());
    end
    op_bus.valid <= 1'b0;

    while (stack_mirror.pending.size() != 0) @(posedge clk);
    repeat (DEPTH + 8) @(posedge clk);
    if (stack_mirror.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/lss_pkg.sv
rtl/lss_in_if.sv
rtl/lss_out_if.sv
rtl/lss_ctrl.sv
rtl/lss_dpath.sv
rtl/lifo_stack_with_search.sv
bench/lifo_stack_with_search_test.sv
